FILE: rtl/fas_pkg.sv
`default_nettype none
package fas_pkg;
	localparam int MANT_WIDTH_DEF = 23;
	localparam int EXP_WIDTH_DEF  = 8;
	// alignment shifts of this many places or more leave only the larger operand
	localparam int GAP_LIMIT      = 32;
	localparam int SHIFT_BITS     = 5;
endpackage
`default_nettype wire

FILE: rtl/fas_core.sv
`default_nettype none
module fas_core #(
	parameter int MANTISSA_WIDTH = 23,
	parameter int EXPONENT_WIDTH = 8
) (
	input  wire logic                                   mode,
	input  wire logic [MANTISSA_WIDTH+EXPONENT_WIDTH:0] operand_a,
	input  wire logic [MANTISSA_WIDTH+EXPONENT_WIDTH:0] operand_b,
	output logic      [MANTISSA_WIDTH+EXPONENT_WIDTH:0] result_word,
	output logic                                        exponent_range_flag
);
	import fas_pkg::*;

	localparam int M  = MANTISSA_WIDTH;
	localparam int E  = EXPONENT_WIDTH;
	localparam int W  = M + E + 1;
	localparam int XW = E + 8;
	localparam int LZW = $clog2(M);

	logic          sa, sb, za, zb, a_big, far, eq, s_big;
	logic [E-1:0]  ea, eb, gap, e_big;
	logic [M-1:0]  ma, mb, m_big, m_sml, aligned;
	logic [SHIFT_BITS-1:0] sh;
	logic [M:0]    sum, diff;
	logic [M-1:0]  p, q, r, add_m, sub_m;
	logic [LZW-1:0] lz;
	logic signed [XW-1:0] add_e, sub_e, e_out;
	logic          sub_s, out_s, is_sub;
	logic [M-1:0]  m_out;

	always_comb begin
		sa = operand_a[W-1];
		sb = operand_b[W-1] ^ mode;
		ea = operand_a[W-2:M];
		eb = operand_b[W-2:M];
		ma = operand_a[M-1:0];
		mb = operand_b[M-1:0];
		za = (ea == '0) && (ma == '0);
		zb = (eb == '0) && (mb == '0);
		a_big = ea >= eb;
		eq = ea == eb;
		gap = a_big ? (ea - eb) : (eb - ea);
		far = 32'(gap) >= 32'(GAP_LIMIT);
		sh = SHIFT_BITS'(gap);
		e_big = a_big ? ea : eb;
		m_big = a_big ? ma : mb;
		m_sml = a_big ? mb : ma;
		s_big = a_big ? sa : sb;
		aligned = m_sml >> sh;
		is_sub = sa != sb;

		// same signs: add and renormalise right
		sum = {1'b0, m_big} + {1'b0, aligned};
		if (eq || sum[M]) begin
			add_m = sum[M:1];
			add_e = XW'(e_big) + XW'(1);
		end else begin
			add_m = sum[M-1:0];
			add_e = XW'(e_big);
		end

		// opposite signs: positive operand is the minuend
		if (!s_big) begin
			p = m_big;
			q = aligned;
		end else begin
			p = aligned;
			q = m_big;
		end
		diff = {1'b0, p} - {1'b0, q};
		sub_s = diff[M];
		r = sub_s ? (q - p) : diff[M-1:0];
		lz = '0;
		for (int i = 0; i < M; i++) begin
			if (r[i]) lz = LZW'(M - 1 - i);
		end
		sub_m = r << lz;
		sub_e = XW'(e_big) - XW'(lz);

		out_s = is_sub ? sub_s : sa;
		m_out = is_sub ? sub_m : add_m;
		e_out = is_sub ? sub_e : add_e;

		result_word = {out_s, e_out[E-1:0], m_out};
		exponent_range_flag = (e_out < 0) || (e_out > XW'((1 << E) - 1));

		if (za && zb) begin
			result_word = '0;
			exponent_range_flag = 1'b0;
		end else if (zb) begin
			result_word = {sa, ea, ma};
			exponent_range_flag = 1'b0;
		end else if (za) begin
			result_word = {sb, eb, mb};
			exponent_range_flag = 1'b0;
		end else if (far) begin
			result_word = {s_big, e_big, m_big};
			exponent_range_flag = 1'b0;
		end else if (is_sub && r == '0) begin
			result_word = '0;
			exponent_range_flag = 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/float_add_sub.sv
// From start to done a transaction passes the input register, then the result register.
// Throughput: one transaction per cycle; busy is never raised.
// The receiver cannot stall: each result is shown on done for one cycle.
// Reset (arst_n low, asynchronous) clears the valid flags; no result follows.
`default_nettype none
module float_add_sub #(
	parameter int MANTISSA_WIDTH = fas_pkg::MANT_WIDTH_DEF,
	parameter int EXPONENT_WIDTH = fas_pkg::EXP_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   mode,
	input  wire logic [MANTISSA_WIDTH+EXPONENT_WIDTH:0] operand_a,
	input  wire logic [MANTISSA_WIDTH+EXPONENT_WIDTH:0] operand_b,
	output logic                                        done,
	output logic      [MANTISSA_WIDTH+EXPONENT_WIDTH:0] result_word,
	output logic                                        exponent_range_flag
);
	import fas_pkg::*;

	localparam int W = MANTISSA_WIDTH + EXPONENT_WIDTH + 1;

	logic         valid_s1, valid_s2;
	logic         mode_s1;
	logic [W-1:0] a_s1, b_s1, res_s2, res_c;
	logic         flag_s2, flag_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1 <= mode;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
		end
		if (valid_s1) begin
			res_s2  <= res_c;
			flag_s2 <= flag_c;
		end
	end

	fas_core #(
		.MANTISSA_WIDTH(MANTISSA_WIDTH),
		.EXPONENT_WIDTH(EXPONENT_WIDTH)
	) u_core (
		.mode(mode_s1),
		.operand_a(a_s1),
		.operand_b(b_s1),
		.result_word(res_c),
		.exponent_range_flag(flag_c)
	);

	assign done = valid_s2;
	assign result_word = res_s2;
	assign exponent_range_flag = flag_s2;

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done) else $error("accepted transaction produced no result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> ##1 !done) else $error("result without a transaction");
endmodule
`default_nettype wire

FILE: test/float_add_sub_checker.sv
module float_add_sub_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        mode,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	input  wire logic        done,
	input  wire logic [31:0] result_word,
	input  wire logic        exponent_range_flag,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [22:0] LEAD_BIT = 23'h400000;

	typedef struct packed {
		logic [31:0] word;
		logic        flag;
	} sum_t;

	sum_t sum_q[$];

	function automatic sum_t pack_sum(logic s, int e, logic [63:0] m, logic fl_in);
		sum_t r;
		r.flag = fl_in | (e < 0) | (e > 255);
		r.word = {s, e[7:0], m[22:0]};
		return r;
	endfunction

	function automatic sum_t add_magnitudes(logic s, int ex, logic [63:0] mx,
			int ey, logic [63:0] my);
		int e;
		logic [63:0] m;
		if (ex == ey)
			return pack_sum(s, ex + 1, (mx + my) >> 1, 1'b0);
		if (ex > ey) begin
			e = ex;
			m = mx + (my >> (ex - ey));
		end else begin
			e = ey;
			m = my + (mx >> (ey - ex));
		end
		if (m > 64'h7fffff) begin
			m = m >> 1;
			e++;
		end
		return pack_sum(s, e, m, 1'b0);
	endfunction

	function automatic sum_t sub_magnitudes(int ex, logic [63:0] mx, int ey,
			logic [63:0] my);
		logic s;
		int e;
		logic [63:0] p, q, r;
		sum_t z;
		s = 1'b0;
		if (ex >= ey) begin
			e = ex;
			p = mx;
			q = my >> (ex - ey);
		end else begin
			e = ey;
			p = mx >> (ey - ex);
			q = my;
		end
		if (p >= q) begin
			r = p - q;
		end else begin
			r = q - p;
			s = 1'b1;
		end
		z = '0;
		if (r == 0)
			return z;
		while (r < LEAD_BIT) begin
			r = r << 1;
			e--;
		end
		return pack_sum(s, e, r, 1'b0);
	endfunction

	function automatic sum_t predict_sum(logic md, logic [31:0] a, logic [31:0] b);
		logic sa, sb, za, zb;
		int ea, eb, ex, ey;
		logic [63:0] ma, mb, mx, my;
		sum_t z;
		sa = a[31];
		sb = b[31] ^ md;
		ea = int'(a[30:23]);
		eb = int'(b[30:23]);
		ma = 64'(a[22:0]);
		mb = 64'(b[22:0]);
		za = (ea == 0) && (ma == 0);
		zb = (eb == 0) && (mb == 0);
		z = '0;
		if (za && zb) return z;
		if (zb) return pack_sum(sa, ea, ma, 1'b0);
		if (za) return pack_sum(sb, eb, mb, 1'b0);
		if (sa == sb) begin
			if (ea - eb >= 32) return pack_sum(sa, ea, ma, 1'b0);
			if (eb - ea >= 32) return pack_sum(sa, eb, mb, 1'b0);
			return add_magnitudes(sa, ea, ma, eb, mb);
		end
		// positive operand is the minuend
		ex = sa ? eb : ea;
		ey = sa ? ea : eb;
		mx = sa ? mb : ma;
		my = sa ? ma : mb;
		if (ex - ey >= 32) return pack_sum(1'b0, ex, mx, 1'b0);
		if (ey - ex >= 32) return pack_sum(1'b1, ey, my, 1'b0);
		return sub_magnitudes(ex, mx, ey, my);
	endfunction

	assign pending = sum_q.size();

	always @(posedge clk or negedge arst_n) begin
		sum_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				sum_q.push_back(predict_sum(mode, operand_a, operand_b));
			if (done) begin
				if (sum_q.size() == 0) begin
					$display("%0t: unexpected transaction word %h flag %b", $time,
						result_word, exponent_range_flag);
					fail_count <= fail_count + 1;
				end else begin
					want = sum_q.pop_front();
					if (want.word !== result_word || want.flag !== exponent_range_flag) begin
						$display("%0t: expected word %h flag %b, actual word %h flag %b",
							$time, want.word, want.flag, result_word, exponent_range_flag);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

FILE: test/float_add_sub_tb.sv
module float_add_sub_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        mode = 1'b0;
	logic [31:0] operand_a = '0;
	logic [31:0] operand_b = '0;
	logic        busy, done, exponent_range_flag;
	logic [31:0] result_word;
	int          fail_count, pending;
	int          idle_pct;
	int          quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	float_add_sub u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.operand_a(operand_a), .operand_b(operand_b), .done(done),
		.result_word(result_word), .exponent_range_flag(exponent_range_flag)
	);

	float_add_sub_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.operand_a(operand_a), .operand_b(operand_b), .done(done),
		.result_word(result_word), .exponent_range_flag(exponent_range_flag),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("float_add_sub verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int e;
		w = $urandom;
		case ($urandom_range(0, 9))
			0: w[30:0] = '0;
			1: begin
				e = $urandom_range(0, 255);
				w[30:23] = e[7:0];
				w[22] = 1'b0;
			end
			2: w[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
			default: w[22] = 1'b1;
		endcase
		return w;
	endfunction

	task automatic send_sum(logic md, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= md;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// pair b with a nearby exponent so most operations overlap in alignment
	task automatic send_random();
		logic [31:0] a, b;
		int e;
		a = random_word();
		b = random_word();
		if ($urandom_range(0, 3) != 0 && b[30:0] != 0) begin
			e = int'(a[30:23]) + int'($urandom_range(0, 8)) - 4;
			if (e < 0) e = 0;
			if (e > 255) e = 255;
			b[30:23] = e[7:0];
			if ($urandom_range(0, 5) == 0) b[30:0] = a[30:0];
		end
		send_sum(1'($urandom_range(0, 1)), a, b);
	endtask

	initial begin
		quiet_cycles = 0;
		idle_pct = 9;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_sum(1'b0, 32'h0, 32'h0);
		send_sum(1'b1, 32'h8000_0000, 32'h0);
		send_sum(1'b0, 32'h0, 32'h4040_0000);
		send_sum(1'b1, 32'h0, 32'h4040_0000);
		send_sum(1'b1, 32'h4040_0000, 32'h0);
		send_sum(1'b0, 32'h4040_0000, 32'h4040_0000);
		send_sum(1'b1, 32'h4040_0000, 32'h4040_0000);
		send_sum(1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
		send_sum(1'b0, 32'hffff_ffff, 32'hffff_ffff);
		send_sum(1'b0, 32'h7fff_ffff, 32'h7f80_0001);
		send_sum(1'b1, 32'h0040_0000, 32'h0060_0000);
		send_sum(1'b0, 32'h0040_0001, 32'h8040_0000);
		send_sum(1'b0, 32'h6040_0000, 32'h2040_0000);
		send_sum(1'b0, 32'h2040_0000, 32'h6040_0000);
		send_sum(1'b1, 32'h6040_0000, 32'h2040_0000);
		send_sum(1'b1, 32'h2040_0000, 32'h6040_0000);
		send_sum(1'b0, 32'h4fc0_0000, 32'h4040_0000);
		send_sum(1'b1, 32'h4000_0001, 32'h3f80_0003);
		send_sum(1'b0, 32'h4000_0003, 32'h4080_0001);
		send_sum(1'b1, 32'h0080_0001, 32'h0080_0000);
		send_sum(1'b0, 32'h7f80_0000, 32'h0000_0000);
		send_sum(1'b1, 32'h8000_0000, 32'h8000_0000);
		repeat (510) send_random();
		idle_pct = 47;
		repeat (510) send_random();
		idle_pct = 0;
		repeat (510) send_random();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("float_add_sub verification clean");
		else
			$display("float_add_sub verification failed");
		$finish;
	end
endmodule
